FILE: src/dcfir_pkg.sv
package dcfir_pkg;

   localparam int TAP_COUNT_DEF   = 51;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEF_BITS_DEF   = 16;

   // widest tap the coefficient function can return, and the index width it takes
   localparam int COEF_MAX_BITS  = 24;
   localparam int TAP_INDEX_BITS = 8;

   localparam int TABLE_LEN = 51;
   localparam int HALF_LEN  = 26;
   localparam int RAW_BITS  = 16;

   // one half of the symmetric low-pass response, unsigned, 2^20 scale
   localparam logic [RAW_BITS-1:0] LP_TAPS [HALF_LEN] = '{
      16'd0,     16'd173,   16'd404,   16'd743,   16'd1242,  16'd1950,  16'd2915,
      16'd4176,  16'd5763,  16'd7694,  16'd9972,  16'd12588, 16'd15513, 16'd18705,
      16'd22107, 16'd25648, 16'd29247, 16'd32815, 16'd36258, 16'd39481, 16'd42392,
      16'd44904, 16'd46944, 16'd48447, 16'd49369, 16'd49679
   };

   // control shared by the history memory and the mac unit
   typedef struct packed {
      logic load;   // new sample pair written, accumulators cleared
      logic issue;  // one tap step: read one history entry, accumulate one product
   } seq_ctl_type;

   // tap k scaled to coef_bits; taps past the table are zero
   function automatic logic [COEF_MAX_BITS-1:0] tap_value(
      input logic [TAP_INDEX_BITS-1:0] k,
      input int                        coef_bits
   );
      logic [TAP_INDEX_BITS-1:0] m;
      logic [COEF_MAX_BITS-1:0]  raw;
      logic [COEF_MAX_BITS-1:0]  res;
      if (k >= TAP_INDEX_BITS'(TABLE_LEN)) begin
         res = '0;
      end else begin
         m   = (k < TAP_INDEX_BITS'(HALF_LEN)) ? k : TAP_INDEX_BITS'(TABLE_LEN - 1) - k;
         raw = COEF_MAX_BITS'(LP_TAPS[m[4:0]]);
         if (coef_bits >= RAW_BITS) begin
            res = raw << (coef_bits - RAW_BITS);
         end else begin
            res = raw >> (RAW_BITS - coef_bits);
         end
      end
      return res;
   endfunction

endpackage

FILE: src/dcfir_chan_if.sv
interface dcfir_req_if #(
   parameter int SAMPLE_BITS = dcfir_pkg::SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] red_ac;
   logic signed [SAMPLE_BITS-1:0] ir_ac;

   modport source (output valid, output red_ac, output ir_ac, input ready);
   modport sink   (input valid, input red_ac, input ir_ac, output ready);
endinterface

interface dcfir_rsp_if #(
   parameter int SAMPLE_BITS = dcfir_pkg::SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] red_filtered;
   logic signed [SAMPLE_BITS-1:0] ir_filtered;

   modport source (output valid, output red_filtered, output ir_filtered, input ready);
   modport sink   (input valid, input red_filtered, input ir_filtered, output ready);
endinterface

FILE: src/dual_channel_fir_lowpass_51.sv
// Two-channel 51-tap symmetric low-pass FIR. Each req beat carries one red and one infrared
// sample. Each rsp beat returns both filtered samples, rounded half up and saturated. The
// histories start at zero, so early outputs sum only the samples seen so far. A single
// two-lane multiply-accumulate unit steps one tap per cycle through one read port of the
// history memory. The last product is then multiplied, accumulated and written to the rsp
// register. req is ready only while the unit is idle, which it is again once the result
// lands, so a new item is accepted only after the last one's result has landed in the rsp
// register. A finished result waits in the rsp register and the next item can start; a
// result that finds that register still full holds the unit in its final step.
module dual_channel_fir_lowpass_51 #(
   parameter int TAP_COUNT   = dcfir_pkg::TAP_COUNT_DEF,
   parameter int SAMPLE_BITS = dcfir_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = dcfir_pkg::COEF_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dcfir_req_if.sink   req_chan,
   dcfir_rsp_if.source rsp_chan
);
   import dcfir_pkg::*;

   localparam int K_BITS = $clog2(TAP_COUNT);
   localparam logic [K_BITS-1:0] K_LAST = K_BITS'(TAP_COUNT - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

   state_type                     state_ff;
   logic [K_BITS-1:0]             k_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] red_out_ff;
   logic signed [SAMPLE_BITS-1:0] ir_out_ff;

   seq_ctl_type                   ctl;
   logic                          accept;
   logic                          out_free;
   logic                          result_done;
   logic                          mac_busy;
   logic [COEF_MAX_BITS-1:0]      tap_full;
   logic [COEF_BITS-1:0]          tap;
   logic signed [SAMPLE_BITS-1:0] hist_red;
   logic signed [SAMPLE_BITS-1:0] hist_ir;
   logic signed [SAMPLE_BITS-1:0] red_q;
   logic signed [SAMPLE_BITS-1:0] ir_q;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   // last product landed and the rsp register can take the result
   assign result_done    = (state_ff == ST_FLUSH) && !mac_busy && out_free;
   assign ctl.load       = accept;
   assign ctl.issue      = (state_ff == ST_RUN);
   assign tap_full       = tap_value(TAP_INDEX_BITS'(k_ff), COEF_BITS);
   assign tap            = tap_full[COEF_BITS-1:0];

   dcfir_hist #(
      .TAP_COUNT   (TAP_COUNT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_hist (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .wr_red (req_chan.red_ac),
      .wr_ir  (req_chan.ir_ac),
      .rd_red (hist_red),
      .rd_ir  (hist_ir)
   );

   dcfir_mac #(
      .TAP_COUNT   (TAP_COUNT),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .tap   (tap),
      .red_x (hist_red),
      .ir_x  (hist_ir),
      .busy  (mac_busy),
      .red_q (red_q),
      .ir_q  (ir_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_chan.ready && !result_done) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_RUN;
                  k_ff     <= '0;
               end
            end
            ST_RUN: begin
               if (k_ff == K_LAST) begin
                  state_ff <= ST_FLUSH;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_FLUSH: begin
               // wait for the last product to land and for the rsp register to free up
               if (result_done) begin
                  rsp_valid_ff <= 1'b1;
                  red_out_ff   <= red_q;
                  ir_out_ff    <= ir_q;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.red_filtered = red_out_ff;
   assign rsp_chan.ir_filtered  = ir_out_ff;

`ifndef SYNTHESIS
   a_rsp_from_flush: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(state_ff) == ST_FLUSH)
      else $error("rsp beat raised outside the flush step");

   a_idle_mac_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !mac_busy)
      else $error("mac pipeline still busy while idle");

   a_tap_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && k_ff != K_LAST) |=> k_ff == K_BITS'($past(k_ff) + 1'b1))
      else $error("tap counter skipped a step");
`endif

endmodule

FILE: src/dcfir_hist.sv
module dcfir_hist #(
   parameter int TAP_COUNT   = dcfir_pkg::TAP_COUNT_DEF,
   parameter int SAMPLE_BITS = dcfir_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dcfir_pkg::seq_ctl_type        ctl,
   input  logic signed [SAMPLE_BITS-1:0] wr_red,
   input  logic signed [SAMPLE_BITS-1:0] wr_ir,
   output logic signed [SAMPLE_BITS-1:0] rd_red,
   output logic signed [SAMPLE_BITS-1:0] rd_ir
);
   import dcfir_pkg::*;

   localparam int SLOT_BITS = $clog2(TAP_COUNT);
   localparam int FILL_BITS = $clog2(TAP_COUNT + 1);
   localparam int WORD_BITS = 2 * SAMPLE_BITS;
   localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(TAP_COUNT - 1);
   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(TAP_COUNT);

   logic [WORD_BITS-1:0] hist_mem_ff [TAP_COUNT];
   logic [SLOT_BITS-1:0] wr_slot_ff;
   logic [SLOT_BITS-1:0] rd_ptr_ff;
   logic [FILL_BITS-1:0] fill_ff;
   logic [WORD_BITS-1:0] rd_word_ff;
   logic                 rd_ok_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         hist_mem_ff[wr_slot_ff] <= {wr_red, wr_ir};
      end
      if (ctl.issue) begin
         rd_word_ff <= hist_mem_ff[rd_ptr_ff];
      end
   end

   // slots are filled in order from zero, so entries below the fill count are written
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
         rd_ok_ff   <= 1'b0;
      end else begin
         if (ctl.load) begin
            wr_slot_ff <= (wr_slot_ff == SLOT_LAST) ? '0 : wr_slot_ff + 1'b1;
            rd_ptr_ff  <= wr_slot_ff;
            if (fill_ff != FILL_FULL) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (ctl.issue) begin
            rd_ptr_ff <= (rd_ptr_ff == '0) ? SLOT_LAST : rd_ptr_ff - 1'b1;
            rd_ok_ff  <= FILL_BITS'(rd_ptr_ff) < fill_ff;
         end
      end
   end

   assign rd_red = rd_ok_ff ? $signed(rd_word_ff[WORD_BITS-1:SAMPLE_BITS]) : '0;
   assign rd_ir  = rd_ok_ff ? $signed(rd_word_ff[SAMPLE_BITS-1:0]) : '0;

endmodule

FILE: src/dcfir_mac.sv
module dcfir_mac #(
   parameter int TAP_COUNT   = dcfir_pkg::TAP_COUNT_DEF,
   parameter int SAMPLE_BITS = dcfir_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = dcfir_pkg::COEF_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dcfir_pkg::seq_ctl_type        ctl,
   input  logic [COEF_BITS-1:0]          tap,
   input  logic signed [SAMPLE_BITS-1:0] red_x,
   input  logic signed [SAMPLE_BITS-1:0] ir_x,
   output logic                          busy,
   output logic signed [SAMPLE_BITS-1:0] red_q,
   output logic signed [SAMPLE_BITS-1:0] ir_q
);
   import dcfir_pkg::*;

   localparam int FRAC      = COEF_BITS + 4;
   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS + 1;
   localparam int ACC_BITS  = SAMPLE_BITS + COEF_BITS + 4 + $clog2(TAP_COUNT);
   localparam int Q_BITS    = ACC_BITS - FRAC;
   localparam logic signed [ACC_BITS-1:0] RND  = ACC_BITS'(64'd1 << (FRAC - 1));
   localparam logic signed [Q_BITS-1:0]   Q_HI = Q_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [Q_BITS-1:0]   Q_LO = Q_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   logic [COEF_BITS-1:0]        tap_ff;
   logic                        stage1_ff;
   logic                        stage2_ff;
   logic signed [PROD_BITS-1:0] prod_red_ff;
   logic signed [PROD_BITS-1:0] prod_ir_ff;
   logic signed [ACC_BITS-1:0]  acc_red_ff;
   logic signed [ACC_BITS-1:0]  acc_ir_ff;

   function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
      input logic signed [ACC_BITS-1:0] acc
   );
      logic signed [ACC_BITS-1:0]    v;
      logic signed [Q_BITS-1:0]      q;
      logic signed [SAMPLE_BITS-1:0] res;
      v = acc + RND;
      q = $signed(v[ACC_BITS-1:FRAC]);
      if (q > Q_HI) begin
         res = Q_HI[SAMPLE_BITS-1:0];
      end else if (q < Q_LO) begin
         res = Q_LO[SAMPLE_BITS-1:0];
      end else begin
         res = q[SAMPLE_BITS-1:0];
      end
      return res;
   endfunction

   // stage 1 lines the tap up with the registered memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
      end else begin
         stage1_ff <= ctl.issue;
         stage2_ff <= stage1_ff;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff <= tap;
      if (stage1_ff) begin
         prod_red_ff <= red_x * $signed({1'b0, tap_ff});
         prod_ir_ff  <= ir_x * $signed({1'b0, tap_ff});
      end
      if (ctl.load) begin
         acc_red_ff <= '0;
         acc_ir_ff  <= '0;
      end else if (stage2_ff) begin
         acc_red_ff <= acc_red_ff + ACC_BITS'(prod_red_ff);
         acc_ir_ff  <= acc_ir_ff + ACC_BITS'(prod_ir_ff);
      end
   end

   assign busy  = stage1_ff | stage2_ff;
   assign red_q = round_sat(acc_red_ff);
   assign ir_q  = round_sat(acc_ir_ff);

endmodule
